FILE: rtl/nncs_pkg.sv
// ---------------------------------------------------------------------------
// NAND netlist cycle simulator - shared definitions
// Command codes, sequencer states and value bank rotation helpers.
// ---------------------------------------------------------------------------
package nncs_pkg;

   typedef enum logic [2:0] {
      KIND_CLEAR  = 3'd0,
      KIND_APPEND = 3'd1,
      KIND_FORCE  = 3'd2,
      KIND_RUN    = 3'd3,
      KIND_READ   = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CMD_READ,
      ST_CMD_EXEC,
      ST_TK_HEAD,
      ST_TK_CNT,
      ST_TK_VAL,
      ST_TK_ACC,
      ST_TK_WR,
      ST_TK_END
   } state_type;

   // three value banks rotate through the roles current, next and older
   localparam int NUM_BANKS = 3;

   typedef logic [1:0] bank_sel_type;

   function automatic bank_sel_type bank_next(input bank_sel_type sel);
      bank_sel_type res;
      res = (sel == bank_sel_type'(NUM_BANKS - 1)) ? '0 : bank_sel_type'(sel + 2'd1);
      return res;
   endfunction

   function automatic bank_sel_type bank_prev(input bank_sel_type sel);
      bank_sel_type res;
      res = (sel == '0) ? bank_sel_type'(NUM_BANKS - 1) : bank_sel_type'(sel - 2'd1);
      return res;
   endfunction

endpackage

FILE: rtl/nand_netlist_cycle_simulator.sv
// ---------------------------------------------------------------------------
// NAND netlist cycle simulator
// Holds a NAND netlist and its gate values in on-chip memories, executes
// editing and read requests, and runs synchronous ticks gate by gate.
// ---------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+--------------------------
//  request  | req_kind, req_gate_index,               | taken when start && !busy
//           | req_source_index, req_force_value,      |
//           | req_tick_count                          |
//  result   | rsp_gate_value, rsp_gate_fanin,         | rsp_valid, one cycle, no
//           | rsp_status                              | back-pressure
//
//  An editing or read request passes ST_CMD_READ and ST_CMD_EXEC, which registers its result.
//  A run steps through the gates in use one by one on every tick, reading
//  their sources in turn over the single read port on the source list
//  and value memories; it ends early once the gate values repeat with period
//  one or two.
//  After reset a clearing pass over all MAX_GATES entries holds busy high.
//  Results cannot be stalled; busy drops in the cycle the result is shown.
// ---------------------------------------------------------------------------
module nand_netlist_cycle_simulator
   import nncs_pkg::*;
#(
   parameter int MAX_GATES = 1024,
   parameter int MAX_FANIN = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [9:0]  req_gate_index,
   input  logic [9:0]  req_source_index,
   input  logic        req_force_value,
   input  logic [31:0] req_tick_count,
   output logic        rsp_valid,
   output logic        rsp_gate_value,
   output logic [4:0]  rsp_gate_fanin,
   output logic        rsp_status
);

   localparam int GW  = $clog2(MAX_GATES);
   localparam int UW  = $clog2(MAX_GATES + 1);
   localparam int FW  = $clog2(MAX_FANIN + 1);
   localparam int SAW = $clog2(MAX_GATES * MAX_FANIN);

   // memories
   logic [GW-1:0] src_mem [MAX_GATES * MAX_FANIN];
   logic [FW-1:0] cnt_mem [MAX_GATES];
   logic          val_mem [NUM_BANKS][MAX_GATES];

   logic [GW-1:0]        src_rd_ff;
   logic [FW-1:0]        cnt_rd_ff;
   logic [NUM_BANKS-1:0] bank_rd_ff;

   logic                 src_we;
   logic [SAW-1:0]       src_waddr;
   logic [SAW-1:0]       src_raddr;
   logic [GW-1:0]        src_wdata;
   logic                 cnt_we;
   logic [GW-1:0]        cnt_waddr;
   logic [GW-1:0]        cnt_raddr;
   logic [FW-1:0]        cnt_wdata;
   logic [NUM_BANKS-1:0] bank_we;
   logic [GW-1:0]        bank_waddr;
   logic [GW-1:0]        bank_raddr;
   logic                 bank_wdata;

   // control and datapath registers
   state_type    state_ff, state_in;
   kind_type     kind_ff, kind_in;
   logic [GW-1:0] g_ff, g_in;
   logic [GW-1:0] src_ff, src_in;
   logic         fv_ff, fv_in;
   logic         g_ok_ff, g_ok_in;
   logic         src_ok_ff, src_ok_in;
   logic [31:0]  rem_ff, rem_in;
   logic [UW-1:0] in_use_ff, in_use_in;
   bank_sel_type ptr_ff, ptr_in;
   logic         have_older_ff, have_older_in;
   logic         changed_ff, changed_in;
   logic         diff2_ff, diff2_in;
   logic [GW-1:0] i_ff, i_in;
   logic [SAW-1:0] base_ff, base_in;
   logic [SAW-1:0] cmd_base_ff, cmd_base_in;
   logic [FW-1:0] j_ff, j_in;
   logic [FW-1:0] cnt_ff, cnt_in;
   logic         acc_ff, acc_in;
   logic         cur_i_ff, cur_i_in;
   logic         old_i_ff, old_i_in;
   logic [GW-1:0] clr_ff, clr_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_value_ff, rsp_value_in;
   logic [4:0]   rsp_fanin_ff, rsp_fanin_in;
   logic         rsp_status_ff, rsp_status_in;

   logic [UW-1:0] g_mark;
   logic [UW-1:0] s_mark;
   logic [31:0]   rem_dec;
   logic          new_val;

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gate_value = rsp_value_ff;
   assign rsp_gate_fanin = rsp_fanin_ff;
   assign rsp_status     = rsp_status_ff;

   assign g_mark  = UW'(g_ff) + UW'(1);
   assign s_mark  = UW'(src_ff) + UW'(1);
   assign rem_dec = rem_ff - 32'd1;
   assign new_val = ~acc_ff;

   always_ff @(posedge clock) begin
      if (src_we) begin
         src_mem[src_waddr] <= src_wdata;
      end
      src_rd_ff <= src_mem[src_raddr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[cnt_raddr];
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_BANKS; k++) begin
         if (bank_we[k]) begin
            val_mem[k][bank_waddr] <= bank_wdata;
         end
         bank_rd_ff[k] <= val_mem[k][bank_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         in_use_ff    <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         in_use_ff    <= in_use_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      g_ff          <= g_in;
      src_ff        <= src_in;
      fv_ff         <= fv_in;
      g_ok_ff       <= g_ok_in;
      src_ok_ff     <= src_ok_in;
      rem_ff        <= rem_in;
      have_older_ff <= have_older_in;
      changed_ff    <= changed_in;
      diff2_ff      <= diff2_in;
      i_ff          <= i_in;
      base_ff       <= base_in;
      cmd_base_ff   <= cmd_base_in;
      j_ff          <= j_in;
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      cur_i_ff      <= cur_i_in;
      old_i_ff      <= old_i_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_fanin_ff  <= rsp_fanin_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      g_in          = g_ff;
      src_in        = src_ff;
      fv_in         = fv_ff;
      g_ok_in       = g_ok_ff;
      src_ok_in     = src_ok_ff;
      rem_in        = rem_ff;
      in_use_in     = in_use_ff;
      ptr_in        = ptr_ff;
      have_older_in = have_older_ff;
      changed_in    = changed_ff;
      diff2_in      = diff2_ff;
      i_in          = i_ff;
      base_in       = base_ff;
      cmd_base_in   = cmd_base_ff;
      j_in          = j_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      cur_i_in      = cur_i_ff;
      old_i_in      = old_i_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = 1'b0;
      rsp_fanin_in  = '0;
      rsp_status_in = 1'b0;

      src_we     = 1'b0;
      src_waddr  = cmd_base_ff + SAW'(cnt_rd_ff);
      src_wdata  = src_ff;
      src_raddr  = base_ff + SAW'(j_ff);
      cnt_we     = 1'b0;
      cnt_waddr  = g_ff;
      cnt_wdata  = '0;
      cnt_raddr  = g_ff;
      bank_we    = '0;
      bank_waddr = g_ff;
      bank_wdata = fv_ff;
      bank_raddr = g_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep counts and all value banks to zero
            cnt_we     = 1'b1;
            cnt_waddr  = clr_ff;
            bank_we    = '1;
            bank_waddr = clr_ff;
            bank_wdata = 1'b0;
            if (clr_ff == GW'(MAX_GATES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + GW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               kind_in   = kind_type'(req_kind);
               g_in      = GW'(req_gate_index);
               src_in    = GW'(req_source_index);
               fv_in     = req_force_value;
               g_ok_in   = (32'(req_gate_index) < MAX_GATES);
               src_ok_in = (32'(req_source_index) < MAX_GATES);
               rem_in    = req_tick_count;
               state_in  = ST_CMD_READ;
            end
         end
         ST_CMD_READ: begin
            cmd_base_in = SAW'(g_ff * MAX_FANIN);
            state_in    = ST_CMD_EXEC;
         end
         ST_CMD_EXEC: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            case (kind_ff)
               KIND_CLEAR: begin
                  if (g_ok_ff) begin
                     if (g_mark > in_use_ff) in_use_in = g_mark;
                     cnt_we = 1'b1;
                  end
               end
               KIND_APPEND: begin
                  if (g_ok_ff && src_ok_ff) begin
                     if (g_mark > in_use_in) in_use_in = g_mark;
                     if (s_mark > in_use_in) in_use_in = s_mark;
                     if (cnt_rd_ff >= FW'(MAX_FANIN)) begin
                        rsp_status_in = 1'b1;
                     end else begin
                        src_we    = 1'b1;
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_rd_ff + FW'(1);
                     end
                  end
               end
               KIND_FORCE: begin
                  if (g_ok_ff) begin
                     if (g_mark > in_use_ff) in_use_in = g_mark;
                     bank_we[ptr_ff] = 1'b1;
                  end
               end
               KIND_RUN: begin
                  if ((rem_ff != 32'd0) && (in_use_ff != '0)) begin
                     rsp_valid_in  = 1'b0;
                     state_in      = ST_TK_HEAD;
                     i_in          = '0;
                     base_in       = '0;
                     changed_in    = 1'b0;
                     diff2_in      = 1'b0;
                     have_older_in = 1'b0;
                  end
               end
               KIND_READ: begin
                  if (g_ok_ff) begin
                     if (g_mark > in_use_ff) in_use_in = g_mark;
                     rsp_value_in = bank_rd_ff[ptr_ff];
                     rsp_fanin_in = 5'(cnt_rd_ff);
                  end
               end
               default: begin
               end
            endcase
         end
         ST_TK_HEAD: begin
            cnt_raddr  = i_ff;
            bank_raddr = i_ff;
            state_in   = ST_TK_CNT;
         end
         ST_TK_CNT: begin
            cnt_in   = cnt_rd_ff;
            cur_i_in = bank_rd_ff[ptr_ff];
            old_i_in = bank_rd_ff[bank_prev(ptr_ff)];
            acc_in   = 1'b1;
            j_in     = '0;
            if (cnt_rd_ff == '0) begin
               state_in = ST_TK_WR;
            end else begin
               src_raddr = base_ff;
               state_in  = ST_TK_VAL;
            end
         end
         ST_TK_VAL: begin
            bank_raddr = src_rd_ff;
            state_in   = ST_TK_ACC;
         end
         ST_TK_ACC: begin
            acc_in = acc_ff & bank_rd_ff[ptr_ff];
            if (FW'(j_ff + FW'(1)) == cnt_ff) begin
               state_in = ST_TK_WR;
            end else begin
               // fetch the next source while this one is folded in
               j_in      = j_ff + FW'(1);
               src_raddr = base_ff + SAW'(j_ff) + SAW'(1);
               state_in  = ST_TK_VAL;
            end
         end
         ST_TK_WR: begin
            bank_we[bank_next(ptr_ff)] = 1'b1;
            bank_waddr = i_ff;
            bank_wdata = new_val;
            changed_in = changed_ff | (new_val != cur_i_ff);
            diff2_in   = diff2_ff | (new_val != old_i_ff);
            if ((UW'(i_ff) + UW'(1)) == in_use_ff) begin
               state_in = ST_TK_END;
            end else begin
               i_in     = i_ff + GW'(1);
               base_in  = base_ff + SAW'(MAX_FANIN);
               state_in = ST_TK_HEAD;
            end
         end
         ST_TK_END: begin
            if (!changed_ff) begin
               // fixed point: hold the current bank
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (have_older_ff && !diff2_ff) begin
               // period two: land on the phase the remaining ticks give
               if (!rem_dec[0]) ptr_in = bank_next(ptr_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               ptr_in        = bank_next(ptr_ff);
               have_older_in = 1'b1;
               if (rem_dec == 32'd0) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  rem_in     = rem_dec;
                  i_in       = '0;
                  base_in    = '0;
                  changed_in = 1'b0;
                  diff2_in   = 1'b0;
                  state_in   = ST_TK_HEAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/nncs_checker.sv
// ---------------------------------------------------------------------------
// NAND netlist cycle simulator - port checker
// Watches the request and result ports of the simulator over time.
// ---------------------------------------------------------------------------
module nncs_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_status
);

   // an accepted request keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // a result only follows a request that was in progress
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result without a request in progress");

   // one result per request: strobes never come back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a full-list flag is only shown with a result
   assert property (@(posedge clock) disable iff (reset)
      rsp_status |-> rsp_valid)
      else $error("status raised outside a result");

endmodule

bind nand_netlist_cycle_simulator nncs_checker u_nncs_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status)
);
